[hdl/medf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medf_pkg
// Shared constants and types for the median/average distance filter.
// ----------------------------------------------------------------------------
package medf_pkg;

  localparam int unsigned WINDOW_DEF      = 7;
  localparam int unsigned SAMPLE_BITS_DEF = 13;

  // Order flags handed from one sorting cell to the next.
  typedef struct packed {
    logic lt;     // cell holds a valid entry <= incoming sample
    logic after;  // the evicted entry sits at or below this cell
  } medf_link_t;

endpackage

[hdl/medf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medf_if
// Valid/ready item channels: distance samples in, smoothed results out.
// ----------------------------------------------------------------------------
interface medf_sample_if #(
  parameter int unsigned SAMPLE_BITS = medf_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface medf_result_if #(
  parameter int unsigned SAMPLE_BITS = medf_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] smoothed;
  logic                   window_full;

  modport source (output valid, output smoothed, output window_full, input ready);
  modport sink   (input valid, input smoothed, input window_full, output ready);
endinterface

[hdl/medf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// medf_cell
// One slot of the sorted window. On each item the oldest entry drops out and
// the new sample is inserted in order; the cell picks its next value from its
// left neighbor, itself, its right neighbor or the new sample.
// ----------------------------------------------------------------------------
module medf_cell #(
  parameter int unsigned WINDOW      = medf_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = medf_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned AGE_BITS    = $clog2(medf_pkg::WINDOW_DEF),
  parameter int unsigned CNT_BITS    = $clog2(medf_pkg::WINDOW_DEF + 1),
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [CNT_BITS-1:0]    fill_i,
  input  medf_pkg::medf_link_t   left_link_i,
  input  logic [SAMPLE_BITS-1:0] left_val_i,
  input  logic [AGE_BITS-1:0]    left_age_i,
  input  logic                   right_lt_i,
  input  logic [SAMPLE_BITS-1:0] right_val_i,
  input  logic [AGE_BITS-1:0]    right_age_i,
  output medf_pkg::medf_link_t   link_o,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic [AGE_BITS-1:0]    age_o
);
  import medf_pkg::*;

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AGE_BITS-1:0]    age_q, age_d;
  logic                   occupied;
  logic                   lt;
  logic                   evict;
  logic                   after;
  logic                   here_lt;
  logic                   left_lt;

  assign occupied = CNT_BITS'(IDX) < fill_i;
  assign lt       = occupied && (val_q <= sample_i);
  assign evict    = (occupied && (age_q == AGE_BITS'(WINDOW - 1)))
                 || (!occupied && (IDX == WINDOW - 1));
  assign after    = left_link_i.after | evict;

  // order flag of the compacted list at this slot and the slot below
  assign here_lt = after ? right_lt_i : lt;
  assign left_lt = left_link_i.after ? lt : left_link_i.lt;

  always_comb begin
    if (here_lt) begin
      val_d = after ? right_val_i : val_q;
      age_d = (after ? right_age_i : age_q) + AGE_BITS'(1);
    end else if (!left_lt) begin
      val_d = left_link_i.after ? val_q : left_val_i;
      age_d = (left_link_i.after ? age_q : left_age_i) + AGE_BITS'(1);
    end else begin
      val_d = sample_i;
      age_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign link_o = '{lt: lt, after: after};
  assign val_o  = val_q;
  assign age_o  = age_q;

endmodule

[hdl/median_ema_distance_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_ema_distance_filter_core
// Sliding-window median of the last WINDOW samples (raw samples until the
// window is full) followed by an exponential average with weight one half.
//
//   channel    dir  content                        handshake
//   sample_i   in   sample                         valid/ready
//   result_o   out  smoothed, window_full          valid/ready
//
// One item per cycle sustained while the output is not stalled. The cell
// chain inserts the sample into the sorted window at accept; the next stage
// reads the middle cell and updates the average into the output register.
// Reset clears fill count, average and the pipeline valids; window cells
// need no reset. A stalled output holds its item while one more item waits
// in the middle stage; sample_i.ready drops only when both are full.
// ----------------------------------------------------------------------------
module median_ema_distance_filter_core #(
  parameter int unsigned WINDOW      = medf_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = medf_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  medf_sample_if.sink   sample_i,
  medf_result_if.source result_o
);
  import medf_pkg::*;

  localparam int unsigned AGE_BITS = $clog2(WINDOW);
  localparam int unsigned CNT_BITS = $clog2(WINDOW + 1);
  localparam int unsigned MID      = WINDOW / 2;

  logic [CNT_BITS-1:0]    fill_q, fill_d;
  logic                   s1_valid_q, s1_valid_d;
  logic [SAMPLE_BITS-1:0] s1_raw_q;
  logic                   s1_full_q;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic                   started_q;
  logic                   out_valid_q, out_valid_d;
  logic                   out_full_q;

  logic                   accept;
  logic                   out_load;
  logic                   s1_adv;
  logic                   full_now;
  logic [SAMPLE_BITS-1:0] median;
  logic [SAMPLE_BITS-1:0] passed;
  logic [SAMPLE_BITS:0]   avg_sum;

  logic [SAMPLE_BITS-1:0] cell_val [WINDOW];
  logic [AGE_BITS-1:0]    cell_age [WINDOW];
  medf_link_t             link [WINDOW+1];

  assign out_load       = !out_valid_q || result_o.ready;
  assign s1_adv         = s1_valid_q && out_load;
  assign sample_i.ready = !s1_valid_q || out_load;
  assign accept         = sample_i.valid && sample_i.ready;
  assign full_now       = fill_q >= CNT_BITS'(WINDOW - 1);

  // sorted window
  assign link[0] = '{lt: 1'b1, after: 1'b0};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lval, rval;
    logic [AGE_BITS-1:0]    lage, rage;
    logic                   rlt;

    if (i == 0) begin : g_first
      assign lval = '0;
      assign lage = '0;
    end else begin : g_inner_l
      assign lval = cell_val[i-1];
      assign lage = cell_age[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign rval = '0;
      assign rage = '0;
      assign rlt  = 1'b0;
    end else begin : g_inner_r
      assign rval = cell_val[i+1];
      assign rage = cell_age[i+1];
      assign rlt  = link[i+2].lt;
    end

    medf_cell #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AGE_BITS),
      .CNT_BITS    (CNT_BITS),
      .IDX         (i)
    ) u_cell (
      .clk_i       (clk_i),
      .shift_i     (accept),
      .sample_i    (sample_i.sample),
      .fill_i      (fill_q),
      .left_link_i (link[i]),
      .left_val_i  (lval),
      .left_age_i  (lage),
      .right_lt_i  (rlt),
      .right_val_i (rval),
      .right_age_i (rage),
      .link_o      (link[i+1]),
      .val_o       (cell_val[i]),
      .age_o       (cell_age[i])
    );
  end

  // median of the full window
  if ((WINDOW % 2) != 0) begin : g_odd
    assign median = cell_val[MID];
  end else begin : g_even
    logic [SAMPLE_BITS:0] mid_sum;
    assign mid_sum = {1'b0, cell_val[MID-1]} + {1'b0, cell_val[MID]};
    assign median  = mid_sum[SAMPLE_BITS:1];
  end

  assign passed  = s1_full_q ? median : s1_raw_q;
  assign avg_sum = {1'b0, passed} + {1'b0, avg_q};
  assign avg_d   = started_q ? avg_sum[SAMPLE_BITS:1] : passed;

  always_comb begin
    fill_d = fill_q;
    if (accept && (fill_q < CNT_BITS'(WINDOW))) begin
      fill_d = fill_q + CNT_BITS'(1);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      avg_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        avg_q     <= avg_d;
        started_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_raw_q  <= sample_i.sample;
      s1_full_q <= full_now;
    end
    if (s1_adv) begin
      out_full_q <= s1_full_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.smoothed    = avg_q;
  assign result_o.window_full = out_full_q;

endmodule

[tb/sv/median_ema_distance_filter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_ema_distance_filter_core_tb
// Self-checking bench for the median/average distance filter. Distance
// samples go in over the valid/ready channel. A tracker class keeps its own
// sample ring, fill count and running average, and predicts every result.
// Results are compared field by field in order. The run covers directed
// extremes and the window fill, then random distance tracks with noise and
// outliers, under four idle/stall phases and one long output hold-off.
// ----------------------------------------------------------------------------
module median_ema_distance_filter_core_tb;

  localparam int unsigned WIN    = medf_pkg::WINDOW_DEF;
  localparam int unsigned SW     = medf_pkg::SAMPLE_BITS_DEF;
  localparam int          MAXV   = (1 << SW) - 1;
  localparam int unsigned LIMIT  = 200000;
  localparam int unsigned N_RAND = 282;

  typedef struct packed {
    logic [SW-1:0] smoothed;
    logic          window_full;
  } filter_result_t;

  class median_tracker;
    logic [SW-1:0]  ring [WIN];
    int unsigned    fill;
    int unsigned    slot;
    logic [SW-1:0]  avg;
    bit             started;
    filter_result_t pending [$];
    int unsigned    errors;

    function void note_sample(logic [SW-1:0] v);
      logic [SW-1:0]  sorted [WIN];
      logic [SW-1:0]  passed;
      logic [SW-1:0]  t;
      logic [SW:0]    sum;
      int             j;
      filter_result_t r;
      ring[slot] = v;
      slot = (slot + 1 >= WIN) ? 0 : slot + 1;
      if (fill < WIN) fill++;
      r.window_full = (fill >= WIN);
      passed = v;
      if (r.window_full) begin
        for (int i = 0; i < WIN; i++) begin
          t = ring[i];
          j = i;
          while (j > 0 && sorted[j-1] > t) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = t;
        end
        if (WIN % 2 != 0) begin
          passed = sorted[WIN/2];
        end else begin
          sum = {1'b0, sorted[WIN/2-1]} + {1'b0, sorted[WIN/2]};
          passed = sum[SW:1];
        end
      end
      if (!started) begin
        avg = passed;
        started = 1'b1;
      end else begin
        sum = {1'b0, passed} + {1'b0, avg};
        avg = sum[SW:1];
      end
      r.smoothed = avg;
      pending.push_back(r);
    endfunction

    function void check_result(logic [SW-1:0] smoothed, logic window_full);
      filter_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: smoothed %0d window_full %0b", smoothed, window_full);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (smoothed !== e.smoothed) begin
        $error("smoothed: expected %0d, got %0d", e.smoothed, smoothed);
        errors++;
      end
      if (window_full !== e.window_full) begin
        $error("window_full: expected %0b, got %0b", e.window_full, window_full);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  medf_sample_if #(.SAMPLE_BITS(SW)) smp_if ();
  medf_result_if #(.SAMPLE_BITS(SW)) res_if ();

  median_ema_distance_filter_core #(
    .WINDOW     (WIN),
    .SAMPLE_BITS(SW)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(smp_if),
    .result_o(res_if)
  );

  median_tracker tracker = new();

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  int          track_cm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: check accepted items, then choose next ready
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (res_if.valid && res_if.ready)
          tracker.check_result(res_if.smoothed, res_if.window_full);
        if (hold_left != 0) begin
          hold_left--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
      end
    end
  end

  task automatic send_sample(input logic [SW-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= v;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    tracker.note_sample(v);
  endtask

  task automatic drain();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic int clamp_cm(int v);
    return (v < 0) ? 0 : (v > MAXV) ? MAXV : v;
  endfunction

  // mostly a slowly moving target with noise, plus outliers and extremes
  function automatic logic [SW-1:0] next_distance();
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(49) == 0) track_cm = $urandom_range(MAXV);
    if (pick < 60) begin
      track_cm = clamp_cm(track_cm + int'($urandom_range(64)) - 32);
      return SW'(clamp_cm(track_cm + int'($urandom_range(16)) - 8));
    end else if (pick < 80) begin
      return SW'($urandom_range(MAXV));
    end else if (pick < 88) begin
      return $urandom_range(1) ? SW'(MAXV) : SW'(0);
    end else if (pick < 94) begin
      return $urandom_range(1) ? SW'(MAXV - $urandom_range(15)) : SW'($urandom_range(15));
    end
    return SW'($urandom & MAXV);
  endfunction

  initial begin
    int unsigned idle_tab  [4];
    int unsigned stall_tab [4];
    logic [SW-1:0] directed [];

    idle_tab  = '{0, 77, 0, 30};
    stall_tab = '{0, 0, 77, 30};
    directed  = '{
      0, MAXV, 0, MAXV, 1, 4096, 'h0AAA,
      'h1555, MAXV, MAXV, MAXV, 0, 0, 0, 0,
      MAXV, MAXV, MAXV, MAXV, 'h0800, 'h0010, MAXV - 1
    };

    rst_ni          = 1'b0;
    smp_if.valid    = 1'b0;
    smp_if.sample   = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    track_cm        = $urandom_range(MAXV);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window fill, first load, extremes
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk_i);
      sender_idle_pct = idle_tab[ph];
      recv_stall_pct  = stall_tab[ph];
      if (ph == 0) hold_left = 60;
      @(posedge clk_i);
      for (int n = 0; n < N_RAND; n++) send_sample(next_distance());
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
